### sv/ppmap_pkg.sv
// Shared constants for the ASCII PPM (P3) pixel parser.
// Character codes, result kind codes and value width; no dependencies.
package ppmap_pkg;

    localparam int VALUE_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int KIND_BITS  = 3;
    localparam int BYTE_BITS  = 8;
    localparam int MDATA_BITS = 4 * OUT_BITS;

    localparam logic [BYTE_BITS-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_BITS-1:0] CH_3     = 8'h33;
    localparam logic [BYTE_BITS-1:0] CH_6     = 8'h36;
    localparam logic [BYTE_BITS-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_BITS-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_WIDTH      = 3'd0,
        KIND_HEIGHT     = 3'd1,
        KIND_MAXVAL     = 3'd2,
        KIND_PIXEL      = 3'd3,
        KIND_BAD_MAGIC  = 3'd4,
        KIND_P6         = 3'd5,
        KIND_INCOMPLETE = 3'd6
    } kind_t;

    // One result item as it leaves the block.
    typedef struct packed {
        kind_t               kind;
        logic [OUT_BITS-1:0] header_value;
        logic [OUT_BITS-1:0] red;
        logic [OUT_BITS-1:0] green;
        logic [OUT_BITS-1:0] blue;
        logic                end_of_row;
    } result_t;

endpackage

### sv/ppm_ascii_pixel_parser_top.sv
// ASCII PPM (P3) pixel parser: byte stream in, header numbers and pixels out.
// Depends on ppmap_pkg for character codes, kind codes and the result type.

// The block takes one file byte per cycle on the s_ side (s_tlast marks the
// last byte of a file) and gives at most one result item per byte on the m_
// side, with the kind on m_tuser. Each byte is held in an input register,
// decoded by a single pass of logic (character class, one multiply-by-ten
// accumulate with saturation, header or pixel assembly) and the result is
// written into an output register that drives the m_ side; a new byte is
// accepted every cycle while m_tready is high. The input and output
// registers are the only buffers: when both are full and the output is
// stalled, s_tready drops. After the last byte of a file the parser returns
// to its reset state and expects a new magic number.
module ppm_ascii_pixel_parser_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ppmap_pkg::BYTE_BITS-1:0]    s_tdata,  // input_byte
    input  logic                               s_tlast,  // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // header_value, red, green, blue (lowest bits first)
    output logic [ppmap_pkg::MDATA_BITS-1:0]   m_tdata,
    output logic [ppmap_pkg::KIND_BITS-1:0]    m_tuser,  // result_kind
    output logic                               m_tlast   // end_of_row
);
    import ppmap_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC0  = 3'd0,
        PH_MAGIC1  = 3'd1,
        PH_WIDTH   = 3'd2,
        PH_HEIGHT  = 3'd3,
        PH_MAXVAL  = 3'd4,
        PH_PIXELS  = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic                  comment;
        logic                  pend;
        logic [VALUE_BITS-1:0] accum;
        logic [VALUE_BITS-1:0] row_width;
        logic [1:0]            comp;
        logic [VALUE_BITS-1:0] red;
        logic [VALUE_BITS-1:0] green;
        logic [VALUE_BITS-1:0] col;
    } pstate_t;

    typedef struct packed {
        pstate_t st;
        logic    hit;
        result_t res;
    } step_t;

    localparam pstate_t PSTATE_RESET = '{
        phase: PH_MAGIC0, comment: 1'b0, pend: 1'b0, accum: '0,
        row_width: '0, comp: 2'd0, red: '0, green: '0, col: '0};

    localparam result_t RESULT_NONE = '{
        kind: KIND_WIDTH, header_value: '0, red: '0, green: '0, blue: '0,
        end_of_row: 1'b0};

    // Hand a finished number to the header or pixel logic.
    function automatic step_t take_number(input pstate_t s, input logic [VALUE_BITS-1:0] v);
        step_t                 r;
        logic [VALUE_BITS-1:0] nxt;
        r     = '{st: s, hit: 1'b0, res: RESULT_NONE};
        nxt   = s.col + VALUE_BITS'(1);
        unique case (s.phase)
            PH_WIDTH:
            begin
                r.st.row_width      = v;
                r.st.phase          = PH_HEIGHT;
                r.hit               = 1'b1;
                r.res.kind          = KIND_WIDTH;
                r.res.header_value  = OUT_BITS'(v);
            end
            PH_HEIGHT:
            begin
                r.st.phase          = PH_MAXVAL;
                r.hit               = 1'b1;
                r.res.kind          = KIND_HEIGHT;
                r.res.header_value  = OUT_BITS'(v);
            end
            PH_MAXVAL:
            begin
                if (v != '0)
                begin
                    r.st.phase = PH_PIXELS;
                end
                r.hit               = 1'b1;
                r.res.kind          = KIND_MAXVAL;
                r.res.header_value  = OUT_BITS'(v);
            end
            PH_PIXELS:
            begin
                priority if (s.comp == 2'd0)
                begin
                    r.st.red  = v;
                    r.st.comp = 2'd1;
                end
                else if (s.comp == 2'd1)
                begin
                    r.st.green = v;
                    r.st.comp  = 2'd2;
                end
                else
                begin
                    r.st.comp = 2'd0;
                    r.hit     = 1'b1;
                    r.res.kind  = KIND_PIXEL;
                    r.res.red   = OUT_BITS'(s.red);
                    r.res.green = OUT_BITS'(s.green);
                    r.res.blue  = OUT_BITS'(v);
                    if (s.row_width != '0 && nxt == s.row_width)
                    begin
                        r.res.end_of_row = 1'b1;
                        nxt              = '0;
                    end
                    r.st.col = nxt;
                end
            end
            default:
            begin
                r.hit = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Input register
    logic                 in_vld_reg, in_vld_next;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_last_reg;

    // Parser state and output register
    pstate_t st_reg, st_next;
    logic    out_vld_reg, out_vld_next;
    result_t out_reg;

    logic    proc;
    step_t   s1, s2;
    logic    is_digit, is_sep, in_body;
    logic [VALUE_BITS+3:0] prod;
    logic [VALUE_BITS-1:0] dig_val;

    assign proc     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;

    assign is_digit = (in_byte_reg >= CH_0) && (in_byte_reg <= CH_9);
    assign is_sep   = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_LF);
    assign in_body  = (st_reg.phase == PH_WIDTH) || (st_reg.phase == PH_HEIGHT) ||
                      (st_reg.phase == PH_MAXVAL) || (st_reg.phase == PH_PIXELS);

    // accum * 10 + digit, saturating at the top of the value range
    always_comb
    begin
        prod = ({st_reg.accum, 3'b000} + {2'b00, st_reg.accum, 1'b0})
             + (VALUE_BITS+4)'(in_byte_reg - CH_0);
        if (prod[VALUE_BITS+3:VALUE_BITS] != '0)
        begin
            dig_val = '1;
        end
        else
        begin
            dig_val = prod[VALUE_BITS-1:0];
        end
    end

    // Byte decode
    always_comb
    begin
        s1 = '{st: st_reg, hit: 1'b0, res: RESULT_NONE};
        unique case (st_reg.phase)
            PH_MAGIC0:
            begin
                if (in_byte_reg == CH_P && !in_last_reg)
                begin
                    s1.st.phase = PH_MAGIC1;
                end
                else
                begin
                    s1.st.phase  = PH_DISCARD;
                    s1.hit       = 1'b1;
                    s1.res.kind  = KIND_BAD_MAGIC;
                end
            end
            PH_MAGIC1:
            begin
                priority if (in_byte_reg == CH_3)
                begin
                    s1.st.phase = PH_WIDTH;
                end
                else if (in_byte_reg == CH_6)
                begin
                    s1.st.phase = PH_DISCARD;
                    s1.hit      = 1'b1;
                    s1.res.kind = KIND_P6;
                end
                else
                begin
                    s1.st.phase = PH_DISCARD;
                    s1.hit      = 1'b1;
                    s1.res.kind = KIND_BAD_MAGIC;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS:
            begin
                if (in_byte_reg == CH_LF)
                begin
                    s1.st.comment = 1'b0;
                end
                if (!s1.st.comment)
                begin
                    priority if (in_byte_reg == CH_HASH)
                    begin
                        s1.st.comment = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        s1.st.accum = dig_val;
                        s1.st.pend  = 1'b1;
                    end
                    else if (is_sep && st_reg.pend)
                    begin
                        s1.st.accum = '0;
                        s1.st.pend  = 1'b0;
                        s1 = take_number(s1.st, st_reg.accum);
                    end
                    else
                    begin
                        s1.hit = 1'b0;
                    end
                end
            end
            default:
            begin
                s1.hit = 1'b0;
            end
        endcase
    end

    // End of file: flush a pending number, flag a partial pixel, restart
    always_comb
    begin
        s2 = s1;
        if (in_last_reg && !s1.hit && in_body)
        begin
            if (s1.st.pend)
            begin
                s2.st.accum = '0;
                s2.st.pend  = 1'b0;
                s2 = take_number(s2.st, s1.st.accum);
            end
            if (!s2.hit && s2.st.phase == PH_PIXELS && s2.st.comp != 2'd0)
            begin
                s2.hit      = 1'b1;
                s2.res      = RESULT_NONE;
                s2.res.kind = KIND_INCOMPLETE;
            end
        end
        st_next = in_last_reg ? PSTATE_RESET : s2.st;
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (proc)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (proc)
        begin
            out_vld_next = s2.hit;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= PSTATE_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (proc)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc && s2.hit)
        begin
            out_reg <= s2.res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red, out_reg.header_value};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.end_of_row;

`ifndef NO_ASSERTIONS
    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.comp != 2'd3)
        else $error("component index out of range");

    a_comp_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.comp != 2'd0 |-> st_reg.phase == PH_PIXELS)
        else $error("partial pixel outside pixel phase");

    a_accum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.pend |-> st_reg.accum == '0)
        else $error("accumulator holds a value with no digits pending");

    a_comment_body: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.comment |-> (st_reg.phase == PH_WIDTH || st_reg.phase == PH_HEIGHT ||
                            st_reg.phase == PH_MAXVAL || st_reg.phase == PH_PIXELS))
        else $error("comment flag set outside the number phases");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> st_reg.phase == PH_MAGIC0 && st_reg.comp == 2'd0)
        else $error("parser did not restart after the last byte");
`endif

endmodule

### tb/sv/ppm_ascii_pixel_parser_top_tb.sv
// Self-checking testbench for the ASCII PPM (P3) pixel parser.
// Depends on ppmap_pkg and ppm_ascii_pixel_parser_top; predicts every header
// number, pixel and error item in step with the byte stream and compares them.
module ppm_ascii_pixel_parser_top_tb;

    import ppmap_pkg::*;

    localparam int unsigned VALUE_MAX   = (1 << VALUE_BITS) - 1;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 250;

    typedef enum logic [2:0] {
        ST_MAGIC_P,
        ST_MAGIC_NUM,
        ST_WIDTH,
        ST_HEIGHT,
        ST_MAXVAL,
        ST_PIXELS,
        ST_DISCARD
    } parse_state_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_BITS-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [MDATA_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]  m_tuser;
    logic                  m_tlast;

    // Parser state as the byte stream leaves it
    parse_state_t          pstate;
    bit                    cmt_open;
    bit                    have_digits;
    logic [OUT_BITS-1:0]   accum;
    logic [OUT_BITS-1:0]   row_len;
    logic [1:0]            comp_idx;
    logic [OUT_BITS-1:0]   red_held;
    logic [OUT_BITS-1:0]   green_held;
    logic [OUT_BITS-1:0]   column;

    result_t               due_results[$];
    logic [7:0]            file_text[$];

    bit                    src_idle;
    bit                    sink_idle;
    int unsigned           hold_req;
    int unsigned           mismatches;
    int unsigned           bytes_sent;
    int unsigned           files_sent;
    int unsigned           results_seen;
    int unsigned           row_ends;
    int unsigned           kind_hits[8];

    ppm_ascii_pixel_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void reset_parser();
        pstate      = ST_MAGIC_P;
        cmt_open    = 1'b0;
        have_digits = 1'b0;
        accum       = '0;
        row_len     = '0;
        comp_idx    = '0;
        red_held    = '0;
        green_held  = '0;
        column      = '0;
    endfunction

    // Place one finished number in the header or the pixel being built
    function automatic bit take_value(input logic [OUT_BITS-1:0] v, output result_t r);
        logic [OUT_BITS-1:0] col_next;
        r = '0;
        take_value = 1'b0;
        case (pstate)
            ST_WIDTH:
            begin
                row_len = v;
                pstate = ST_HEIGHT;
                r.kind = KIND_WIDTH;
                r.header_value = v;
                take_value = 1'b1;
            end
            ST_HEIGHT:
            begin
                pstate = ST_MAXVAL;
                r.kind = KIND_HEIGHT;
                r.header_value = v;
                take_value = 1'b1;
            end
            ST_MAXVAL:
            begin
                // a zero maxval leaves the header waiting for another one
                if (v != 0)
                    pstate = ST_PIXELS;
                r.kind = KIND_MAXVAL;
                r.header_value = v;
                take_value = 1'b1;
            end
            ST_PIXELS:
            begin
                if (comp_idx == 2'd0)
                begin
                    red_held = v;
                    comp_idx = 2'd1;
                end
                else if (comp_idx == 2'd1)
                begin
                    green_held = v;
                    comp_idx = 2'd2;
                end
                else
                begin
                    col_next = column + 1'b1;
                    comp_idx = 2'd0;
                    r.kind = KIND_PIXEL;
                    if (row_len != 0 && col_next == row_len)
                    begin
                        r.end_of_row = 1'b1;
                        col_next = '0;
                    end
                    column = col_next;
                    r.red = red_held;
                    r.green = green_held;
                    r.blue = v;
                    take_value = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic bit parse_byte(input logic [7:0] ch, input bit last, output result_t r);
        bit                  got;
        int unsigned         v;
        logic [OUT_BITS-1:0] num;
        r = '0;
        got = 1'b0;
        if (pstate == ST_MAGIC_P)
        begin
            if (ch == CH_P && !last)
                pstate = ST_MAGIC_NUM;
            else
            begin
                pstate = ST_DISCARD;
                r.kind = KIND_BAD_MAGIC;
                got = 1'b1;
            end
        end
        else if (pstate == ST_MAGIC_NUM)
        begin
            if (ch == CH_3)
                pstate = ST_WIDTH;
            else
            begin
                pstate = ST_DISCARD;
                r.kind = (ch == CH_6) ? KIND_P6 : KIND_BAD_MAGIC;
                got = 1'b1;
            end
        end
        else if (pstate >= ST_WIDTH && pstate <= ST_PIXELS)
        begin
            if (ch == CH_LF)
                cmt_open = 1'b0;
            if (!cmt_open)
            begin
                if (ch == CH_HASH)
                    cmt_open = 1'b1;
                else if (ch >= CH_0 && ch <= CH_9)
                begin
                    v = accum * 10 + (ch - CH_0);
                    if (v > VALUE_MAX)
                        v = VALUE_MAX;
                    accum = v[OUT_BITS-1:0];
                    have_digits = 1'b1;
                end
                else if ((ch == CH_SPACE || ch == CH_LF) && have_digits)
                begin
                    num = accum;
                    accum = '0;
                    have_digits = 1'b0;
                    got = take_value(num, r);
                end
            end
        end
        if (last)
        begin
            // flush a pending run, then report a pixel left half built
            if (!got && pstate >= ST_WIDTH && pstate <= ST_PIXELS)
            begin
                if (have_digits)
                begin
                    num = accum;
                    accum = '0;
                    have_digits = 1'b0;
                    got = take_value(num, r);
                end
                if (!got && pstate == ST_PIXELS && comp_idx != 0)
                begin
                    r = '0;
                    r.kind = KIND_INCOMPLETE;
                    got = 1'b1;
                end
            end
            reset_parser();
        end
        return got;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Any byte that neither builds, ends a number nor opens a comment
    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_0 && b <= CH_9) || b == CH_SPACE || b == CH_LF || b == CH_HASH);
        return b;
    endfunction

    function automatic int unsigned pick_value();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return $urandom_range(0, 9);
        if (r < 14)
            return $urandom_range(0, 255);
        if (r < 17)
            return $urandom_range(0, VALUE_MAX);
        if (r < 18)
            return VALUE_MAX;
        if (r < 19)
            return $urandom_range(VALUE_MAX - 5, VALUE_MAX + 5);
        return $urandom_range(VALUE_MAX + 1, 32'hFFFF_FFFF);
    endfunction

    // Append one byte to the file being built
    task automatic put_byte(input logic [7:0] b);
        file_text.insert(file_text.size(), b);
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic add_sep();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 19);
        if (r < 12)
            put_byte(r[0] ? CH_SPACE : CH_LF);
        else if (r < 15)
        begin
            repeat ($urandom_range(2, 4))
                put_byte($urandom_range(0, 1) ? CH_SPACE : CH_LF);
        end
        else if (r < 18)
        begin
            put_byte(CH_HASH);
            repeat ($urandom_range(0, 8))
            begin
                b = 8'($urandom_range(0, 255));
                put_byte((b == CH_LF) ? CH_SPACE : b);
            end
            put_byte(CH_LF);
        end
        else
        begin
            put_byte(pick_junk());
            put_byte(CH_SPACE);
        end
    endtask

    task automatic add_number(input int unsigned v);
        string txt;
        int    i;
        txt = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            txt = {"0", txt};
        for (i = 0; i < txt.len(); i++)
        begin
            put_byte(txt[i]);
            // junk inside a run is skipped without ending it
            if (i + 1 < txt.len() && $urandom_range(0, 15) == 0)
                put_byte(pick_junk());
        end
    endtask

    task automatic build_p3_file();
        int unsigned vals[$];
        int unsigned nvals;
        int unsigned keep;
        int          i;
        file_text.delete();
        add_str("P3");
        if ($urandom_range(0, 1))
            add_sep();
        vals.insert(vals.size(), ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
        vals.insert(vals.size(), pick_value());
        if ($urandom_range(0, 6) == 0)
            vals.insert(vals.size(), 0);
        vals.insert(vals.size(), pick_value());
        nvals = 3 * $urandom_range(0, 10);
        if ($urandom_range(0, 4) == 0)
            nvals += $urandom_range(1, 2);
        repeat (nvals)
            vals.insert(vals.size(), pick_value());
        // now and then cut the file short inside the header
        if ($urandom_range(0, 19) == 0)
        begin
            keep = $urandom_range(0, 2);
            while (vals.size() > keep)
                void'(vals.pop_back());
        end
        for (i = 0; i < vals.size(); i++)
        begin
            if (i > 0)
                add_sep();
            add_number(vals[i]);
        end
        if ($urandom_range(0, 1))
            add_sep();
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        int unsigned gap;
        result_t     r;
        gap = src_idle ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (parse_byte(b, last, r))
            due_results.insert(due_results.size(), r);
        bytes_sent++;
        if (last)
            files_sent++;
    endtask

    task automatic send_bytes(input int lo, input int hi);
        int i;
        for (i = lo; i < hi; i++)
            send_byte(file_text[i], i == file_text.size() - 1);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    // One-byte file, P6, then a file with zero maxval, saturation, junk,
    // a comment, a one-pixel row and a pixel left unfinished at the end
    task automatic test_directed();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        file_text.delete();
        put_byte(8'h00);
        send_bytes(0, file_text.size());
        file_text.delete();
        add_str("P6");
        send_bytes(0, file_text.size());
        file_text.delete();
        add_str("P31 1 0 9 99999 ");
        put_byte(8'hFF);
        add_str("#\n1 2 3");
        send_bytes(0, file_text.size());
    endtask

    task automatic test_random_files(input int unsigned budget, input bit with_idle);
        int unsigned clean;
        int unsigned pick;
        src_idle = with_idle;
        sink_idle = with_idle;
        clean = 0;
        while (clean < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                build_p3_file();
                clean += file_text.size();
            end
            else if (pick < 90)
            begin
                file_text.delete();
                put_byte(($urandom_range(0, 3) != 0) ? CH_P : 8'($urandom_range(0, 255)));
                put_byte($urandom_range(0, 1) ? CH_6 : 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 8))
                    put_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                file_text.delete();
                repeat ($urandom_range(1, 16))
                    put_byte(8'($urandom_range(0, 255)));
            end
            send_bytes(0, file_text.size());
        end
    endtask

    // Hold the output off for a long stretch while bytes keep coming
    task automatic test_output_hold();
        int i;
        src_idle = 1'b0;
        sink_idle = 1'b1;
        hold_req = HOLD_CYCLES;
        file_text.delete();
        add_str("P3 2 2 255\n");
        for (i = 0; i < 12; i++)
        begin
            add_number(pick_value());
            add_sep();
        end
        send_bytes(0, file_text.size());
    endtask

    // Stop mid-file until every result so far has come out
    task automatic test_drain_pause();
        int half;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        repeat (3)
        begin
            build_p3_file();
            half = file_text.size() / 2;
            send_bytes(0, half);
            s_tvalid <= 1'b0;
            wait_drained();
            send_bytes(half, file_text.size());
        end
    endtask

    function automatic void check_field(input string what, input logic [OUT_BITS-1:0] want,
                                        input logic [OUT_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser <= KIND_INCOMPLETE)
                kind_hits[m_tuser]++;
            if (m_tuser == KIND_PIXEL && m_tlast)
                row_ends++;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with none due, expected nothing, got kind %0d", $time,
                         m_tuser);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("result_kind", want.kind, m_tuser);
                check_field("header_value", want.header_value, m_tdata[0*OUT_BITS +: OUT_BITS]);
                check_field("red", want.red, m_tdata[1*OUT_BITS +: OUT_BITS]);
                check_field("green", want.green, m_tdata[2*OUT_BITS +: OUT_BITS]);
                check_field("blue", want.blue, m_tdata[3*OUT_BITS +: OUT_BITS]);
                check_field("end_of_row", want.end_of_row, m_tlast);
            end
        end
    end

    // Output side: random stalls plus a long hold when one is requested
    initial
    begin
        int unsigned hold_left;
        int unsigned sink_wait;
        hold_left = 0;
        sink_wait = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (sink_wait != 0)
            begin
                m_tready <= 1'b0;
                sink_wait--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_idle && $urandom_range(0, 2) == 0)
                    sink_wait = pick_gap();
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        hold_req = 0;
        mismatches = 0;
        bytes_sent = 0;
        files_sent = 0;
        results_seen = 0;
        row_ends = 0;
        reset_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_files(300, 1'b0);
        test_random_files(1700, 1'b1);
        test_output_hold();
        test_drain_pause();

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d files; checked %0d results, %0d of them ending a row.",
                 bytes_sent, files_sent, results_seen, row_ends);
        $display("Kinds seen: width %0d, height %0d, maxval %0d, pixel %0d,",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
        $display("  bad magic %0d, P6 %0d, incomplete %0d.",
                 kind_hits[4], kind_hits[5], kind_hits[6]);
        if (mismatches == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0t: %0d mismatches, %0d results never arrived", $time, mismatches,
                     due_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
